>>> rtl/lrk4_pkg.sv
// Package with the fixed-point types, payload structs and arithmetic helpers of the Lorenz RK4 core.
`default_nettype none
package lrk4_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int StepBits = 16;
  localparam int CoefBits = 22;
  localparam int TagBits  = 8;
  localparam int ProdBits = 2 * WordBits;

  localparam logic signed [WordBits-1:0] WMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WMin = {1'b1, {(WordBits-1){1'b0}}};

  // Update pass modes: half step, full step, final combine.
  localparam logic [1:0] ModeHalf = 2'd0;
  localparam logic [1:0] ModeFull = 2'd1;
  localparam logic [1:0] ModeLast = 2'd2;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [ProdBits-1:0] prod_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_STEP  = 2'd0,
    REG_SIGMA = 2'd1,
    REG_BETA  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [CoefBits-1:0] rho_coeff;
    logic [TagBits-1:0]  traj_tag;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_z;
    logic [TagBits-1:0] out_tag;
    logic               overflow;
  } out_req_t;

  // Operand set handed to the derivative unit and back to the update unit.
  typedef struct packed {
    word_t x0;
    word_t x1;
    word_t x2;
    word_t p0;
    word_t p1;
    word_t p2;
    word_t rho;
    word_t acc0;
    word_t acc1;
    word_t acc2;
    logic [TagBits-1:0] tag;
    logic               ovf;
  } lane_t;

  typedef struct packed {
    logic [StepBits-1:0] step;
    logic [CoefBits-1:0] sigma;
    logic [CoefBits-1:0] beta;
  } cfg_t;

  // Saturating add; bit 0 of ovf reports clipping.
  function automatic word_t sat_add(input word_t a, input word_t b, output logic ovf);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    ovf = s[WordBits] != s[WordBits-1];
    if (!ovf) sat_add = s[WordBits-1:0];
    else if (s[WordBits]) sat_add = WMin;
    else sat_add = WMax;
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b, output logic ovf);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} - {b[WordBits-1], b};
    ovf = s[WordBits] != s[WordBits-1];
    if (!ovf) sat_sub = s[WordBits-1:0];
    else if (s[WordBits]) sat_sub = WMin;
    else sat_sub = WMax;
  endfunction

  // Rescale an exact product to the word with saturation (floor shift).
  function automatic word_t sat_scale(input prod_t p, output logic ovf);
    prod_t sh;
    sh = p >>> FracBits;
    ovf = (sh > prod_t'(WMax)) || (sh < prod_t'(WMin));
    if (!ovf) sat_scale = sh[WordBits-1:0];
    else if (sh[ProdBits-1]) sat_scale = WMin;
    else sat_scale = WMax;
  endfunction

  function automatic prod_t smul(input word_t a, input word_t b);
    smul = prod_t'(a) * prod_t'(b);
  endfunction

  // Signed divide by six, truncating toward zero, by reciprocal multiply.
  function automatic word_t div6(input word_t v);
    logic [WordBits-1:0] mag;
    logic [WordBits+3:0] mulr;
    logic [2*WordBits+3:0] q;
    logic [WordBits-1:0] qw;
    logic [WordBits+2:0] rem;
    mag = v[WordBits-1] ? (~v + 1'b1) : v;
    mulr = (({{(WordBits+3){1'b0}}, 1'b1} << (WordBits + 2)) / 6) + 1'b1;
    q = ({{(WordBits+4){1'b0}}, mag} * {{WordBits{1'b0}}, mulr}) >> (WordBits + 2);
    qw = q[WordBits-1:0];
    rem = {3'b000, mag} - ({3'b000, qw} * (WordBits+3)'(6));
    if (rem[WordBits+2]) qw = qw - 1'b1;
    else if (rem >= (WordBits+3)'(6)) qw = qw + 1'b1;
    div6 = v[WordBits-1] ? word_t'(~qw + 1'b1) : word_t'(qw);
  endfunction

endpackage
`default_nettype wire

>>> rtl/lorenz_rk4_step_core.sv
// Lorenz RK4 step core: four derivative passes and four update passes in one pipeline.
// Stages: input register, 4 derivative and 4 update stages per pass, output register.
// Throughput: one request per cycle without stall; four derivative units, one per pass.
// A stall on the output freezes the whole pipeline, with a skid-free global enable.
// Reset (rst, synchronous) clears all valid bits and loads the default dt, sigma and beta.
`default_nettype none
module lorenz_rk4_step_core
  import lrk4_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire in_req_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output out_req_t out_data,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [CoefBits-1:0] cfg_data
);

  cfg_t cfg;
  logic en;
  lane_t lane0;
  logic v0;
  logic [3:0] dv, uv;
  lane_t dl [4];
  lane_t ul [4];
  word_t dd0 [4];
  word_t dd1 [4];
  word_t dd2 [4];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step <= StepBits'(655);
      cfg.sigma <= CoefBits'(655360);
      cfg.beta <= CoefBits'(174763);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:  cfg.step <= cfg_data[StepBits-1:0];
        REG_SIGMA: cfg.sigma <= cfg_data;
        REG_BETA:  cfg.beta <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline moves whenever the output register is free.
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // Input stage: load the start state into the lane.
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lane0.x0 <= in_data.pos_x;
      lane0.x1 <= in_data.pos_y;
      lane0.x2 <= in_data.pos_z;
      lane0.p0 <= in_data.pos_x;
      lane0.p1 <= in_data.pos_y;
      lane0.p2 <= in_data.pos_z;
      lane0.rho <= word_t'({{(WordBits-CoefBits){1'b0}}, in_data.rho_coeff});
      lane0.acc0 <= '0;
      lane0.acc1 <= '0;
      lane0.acc2 <= '0;
      lane0.tag <= in_data.traj_tag;
      lane0.ovf <= 1'b0;
    end
  end

  // Four derivative and update passes.
  for (genvar g = 0; g < 4; g++) begin : g_pass
    lrk4_deriv u_deriv (
      .clk, .rst, .en,
      .in_valid((g == 0) ? v0 : uv[(g == 0) ? 0 : g-1]),
      .in_lane((g == 0) ? lane0 : ul[(g == 0) ? 0 : g-1]),
      .cfg,
      .out_valid(dv[g]), .out_lane(dl[g]),
      .d0(dd0[g]), .d1(dd1[g]), .d2(dd2[g])
    );
    lrk4_update u_update (
      .clk, .rst, .en,
      .in_valid(dv[g]), .in_lane(dl[g]),
      .d0(dd0[g]), .d1(dd1[g]), .d2(dd2[g]),
      .cfg,
      .mode((g == 3) ? ModeLast : ((g == 2) ? ModeFull : ModeHalf)),
      .dbl((g == 1) || (g == 2)),
      .out_valid(uv[g]), .out_lane(ul[g])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= uv[3];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.next_x <= ul[3].p0;
      out_data.next_y <= ul[3].p1;
      out_data.next_z <= ul[3].p2;
      out_data.out_tag <= ul[3].tag;
      out_data.overflow <= ul[3].ovf;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lrk4_deriv.sv
// Four-stage Lorenz derivative unit: differences, products, rescale, final subtract.
`default_nettype none
module lrk4_deriv
  import lrk4_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire lane_t in_lane,
  input  wire cfg_t cfg,
  output logic out_valid,
  output lane_t out_lane,
  output word_t d0,
  output word_t d1,
  output word_t d2
);

  logic [3:0] vld;
  lane_t l1, l2, l3;
  word_t a_yx, a_rz, a_p0, a_p1, a_p2;
  prod_t m_sx, m_xr, m_xy, m_bz;
  word_t s_sx, s_xr, s_xy, s_bz, s_p1;
  logic o1, o2, o3, o4, o5, o6, o7, o8, o9;
  lane_t l1_next, l3_next, out_next;
  word_t s_sx_n, s_xr_n, s_xy_n, s_bz_n;
  word_t d0_n, d1_n, d2_n;

  // Valid shift line, advancing only when the pipe moves.
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[2:0], in_valid};
  end
  assign out_valid = vld[3];

  // Stage one: differences.
  always_comb begin
    l1_next = in_lane;
    l1_next.p0 = sat_sub(in_lane.p1, in_lane.p0, o1);
    l1_next.p2 = sat_sub(in_lane.rho, in_lane.p2, o2);
    l1_next.ovf = in_lane.ovf | o1 | o2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l1 <= l1_next;
      a_yx <= l1_next.p0;
      a_rz <= l1_next.p2;
      a_p0 <= in_lane.p0;
      a_p1 <= in_lane.p1;
      a_p2 <= in_lane.p2;
    end
  end

  // Stage two: four products.
  always_ff @(posedge clk) begin
    if (en) begin
      l2 <= l1;
      m_sx <= smul(word_t'({{(WordBits-CoefBits){1'b0}}, cfg.sigma}), a_yx);
      m_xr <= smul(a_p0, a_rz);
      m_xy <= smul(a_p0, a_p1);
      m_bz <= smul(word_t'({{(WordBits-CoefBits){1'b0}}, cfg.beta}), a_p2);
      s_p1 <= a_p1;
    end
  end

  // Stage three: rescale with saturation.
  always_comb begin
    s_sx_n = sat_scale(m_sx, o3);
    s_xr_n = sat_scale(m_xr, o4);
    s_xy_n = sat_scale(m_xy, o5);
    s_bz_n = sat_scale(m_bz, o6);
    l3_next = l2;
    l3_next.ovf = l2.ovf | o3 | o4 | o5 | o6;
    l3_next.p1 = s_p1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l3 <= l3_next;
      s_sx <= s_sx_n;
      s_xr <= s_xr_n;
      s_xy <= s_xy_n;
      s_bz <= s_bz_n;
    end
  end

  // Stage four: closing subtractions.
  always_comb begin
    d0_n = s_sx;
    d1_n = sat_sub(s_xr, l3.p1, o7);
    d2_n = sat_sub(s_xy, s_bz, o8);
    o9 = 1'b0;
    out_next = l3;
    out_next.ovf = l3.ovf | o7 | o8 | o9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= out_next;
      d0 <= d0_n;
      d1 <= d1_n;
      d2 <= d2_n;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lrk4_update.sv
// Four-stage RK4 update unit: accumulate k, scale by dt, halve, keep or divide, form probe or result.
`default_nettype none
module lrk4_update
  import lrk4_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire lane_t in_lane,
  input  wire word_t d0,
  input  wire word_t d1,
  input  wire word_t d2,
  input  wire cfg_t cfg,
  // ModeHalf: half step, ModeFull: full step, ModeLast: final combine
  input  wire logic [1:0] mode,
  // weight of k in the accumulator: 1 or 2
  input  wire logic dbl,
  output logic out_valid,
  output lane_t out_lane
);

  logic [3:0] vld;
  lane_t l1, l2, l3, l1_next, l3_next, o_next;
  word_t sel0, sel1, sel2, sel0_n, sel1_n, sel2_n;
  prod_t m0, m1, m2;
  word_t dt;
  logic [8:0] ov;
  word_t t0, t1, t2, k0, k1, k2, a0, a1, a2;
  word_t s0, s1, s2;
  logic q0, q1, q2, r0, r1, r2;

  assign dt = word_t'({{(WordBits-StepBits){1'b0}}, cfg.step});

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[2:0], in_valid};
  end
  assign out_valid = vld[3];

  // Stage one: add k into the running sum, pick the value to scale.
  always_comb begin
    k0 = dbl ? sat_add(d0, d0, ov[0]) : d0;
    k1 = dbl ? sat_add(d1, d1, ov[1]) : d1;
    k2 = dbl ? sat_add(d2, d2, ov[2]) : d2;
    if (!dbl) ov[2:0] = 3'b000;
    a0 = sat_add(in_lane.acc0, k0, ov[3]);
    a1 = sat_add(in_lane.acc1, k1, ov[4]);
    a2 = sat_add(in_lane.acc2, k2, ov[5]);
    l1_next = in_lane;
    ov[8:6] = 3'b000;
    if (mode == ModeLast) begin
      // The last term closes the sum, which is the value to scale; the sum started at zero with k1.
      l1_next.acc0 = a0;
      l1_next.acc1 = a1;
      l1_next.acc2 = a2;
      sel0_n = a0;
      sel1_n = a1;
      sel2_n = a2;
    end else begin
      l1_next.acc0 = a0;
      l1_next.acc1 = a1;
      l1_next.acc2 = a2;
      sel0_n = d0;
      sel1_n = d1;
      sel2_n = d2;
    end
    l1_next.ovf = in_lane.ovf | (|ov);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l1 <= l1_next;
      sel0 <= sel0_n;
      sel1 <= sel1_n;
      sel2 <= sel2_n;
    end
  end

  // Stage two: multiply by dt.
  always_ff @(posedge clk) begin
    if (en) begin
      l2 <= l1;
      m0 <= smul(sel0, dt);
      m1 <= smul(sel1, dt);
      m2 <= smul(sel2, dt);
    end
  end

  // Stage three: rescale, then halve (half step), keep (full step) or divide by six (final combine).
  always_comb begin
    t0 = sat_scale(m0, q0);
    t1 = sat_scale(m1, q1);
    t2 = sat_scale(m2, q2);
    unique case (mode)
      ModeHalf: begin
        t0 = t0 >>> 1;
        t1 = t1 >>> 1;
        t2 = t2 >>> 1;
      end
      ModeLast: begin
        t0 = div6(t0);
        t1 = div6(t1);
        t2 = div6(t2);
      end
      ModeFull: begin
      end
      default: begin
      end
    endcase
    l3_next = l2;
    l3_next.ovf = l2.ovf | q0 | q1 | q2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l3 <= l3_next;
      s0 <= t0;
      s1 <= t1;
      s2 <= t2;
    end
  end

  // Stage four: add the scaled step to the start state.
  always_comb begin
    o_next = l3;
    o_next.p0 = sat_add(l3.x0, s0, r0);
    o_next.p1 = sat_add(l3.x1, s1, r1);
    o_next.p2 = sat_add(l3.x2, s2, r2);
    o_next.ovf = l3.ovf | r0 | r1 | r2;
  end
  always_ff @(posedge clk) begin
    if (en) out_lane <= o_next;
  end

endmodule
`default_nettype wire
